/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is high
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also runs through reset
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/otmr_pkg.sv */
`default_nettype none

package otmr_pkg;

   localparam int unsigned ID_W     = 32;
   localparam int unsigned DELAY_W  = 32;
   localparam int unsigned TIME_W   = 64;
   localparam int unsigned MAX_FIRE = 16;
   localparam int unsigned FCNT_W   = $clog2(MAX_FIRE);

   localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
   localparam logic [ID_W-1:0] ID_LAST  = '1;

   typedef enum logic [1:0] {
      CMD_TIMEOUT  = 2'd0,
      CMD_INTERVAL = 2'd1,
      CMD_CLEAR    = 2'd2,
      CMD_TICK     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_ASSIGNED = 3'd0,
      KIND_FIRED    = 3'd1,
      KIND_CLEARED  = 3'd2,
      KIND_FULL     = 3'd3,
      KIND_NONE     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [DELAY_W-1:0] delay;
      logic               periodic;
      logic [TIME_W-1:0]  deadline;
   } slot_type;

   // per-cycle view of the check stage
   typedef struct packed {
      logic vld;
      logic done;
      logic clr_hit;
      logic due;
   } chk_type;

   // accumulated over one scan
   typedef struct packed {
      logic match_found;
      logic free_found;
      logic best_found;
      logic best_periodic;
      logic more;
   } scan_res_type;

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [DELAY_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {{(TIME_W - DELAY_W + 1){1'b0}}, b};
      return s[TIME_W] ? '1 : s[TIME_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* sv/otmr_ram.sv */
`default_nettype none

module otmr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/otmr_scan.sv */
`default_nettype none

module otmr_scan #(
   parameter int unsigned NUM_SLOTS = 16,
   parameter int unsigned IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire otmr_pkg::cmd_type            cmd,
   input  wire logic                         pass0,
   input  wire logic [otmr_pkg::ID_W-1:0]    next_id,
   input  wire logic [otmr_pkg::ID_W-1:0]    target,
   input  wire logic [otmr_pkg::TIME_W-1:0]  now,
   input  wire otmr_pkg::slot_type           rd_slot,
   input  wire logic                         slot_valid,
   input  wire logic                         slot_due,
   output logic      [IW-1:0]                rd_addr,
   output otmr_pkg::chk_type                 chk,
   output logic      [IW-1:0]                chk_idx,
   output otmr_pkg::scan_res_type            res,
   output logic      [IW-1:0]                match_idx,
   output logic      [IW-1:0]                free_idx,
   output logic      [IW-1:0]                best_idx,
   output logic      [otmr_pkg::ID_W-1:0]    best_id,
   output logic      [otmr_pkg::DELAY_W-1:0] best_delay
);

   import otmr_pkg::*;

   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

   logic [IW-1:0]      iss_ff, iss_in;
   logic               busy_ff, busy_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IW-1:0]      chk_idx_ff, chk_idx_in;

   logic               match_found_ff, match_found_in;
   logic [IW-1:0]      match_idx_ff, match_idx_in;
   logic               free_found_ff, free_found_in;
   logic [IW-1:0]      free_idx_ff, free_idx_in;
   logic               best_found_ff, best_found_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   logic [ID_W-1:0]    best_id_ff, best_id_in;
   logic [DELAY_W-1:0] best_delay_ff, best_delay_in;
   logic               best_periodic_ff, best_periodic_in;
   logic               more_ff, more_in;

   logic is_set;
   logic due;

   // address issue, one slot a cycle
   always_comb begin
      iss_in     = iss_ff;
      busy_in    = busy_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = iss_ff;
      if (start) begin
         iss_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         chk_vld_in = 1'b1;
         iss_in     = iss_ff + 1'b1;
         if (iss_ff == LAST_IDX) begin
            busy_in = 1'b0;
            iss_in  = '0;
         end
      end
   end

   assign is_set = (cmd == CMD_TIMEOUT) || (cmd == CMD_INTERVAL);
   assign due    = chk_vld_ff && (cmd == CMD_TICK) &&
                   (pass0 ? (slot_valid && (now >= rd_slot.deadline)) : slot_due);

   always_comb begin
      match_found_in   = match_found_ff;
      match_idx_in     = match_idx_ff;
      free_found_in    = free_found_ff;
      free_idx_in      = free_idx_ff;
      best_found_in    = best_found_ff;
      best_idx_in      = best_idx_ff;
      best_id_in       = best_id_ff;
      best_delay_in    = best_delay_ff;
      best_periodic_in = best_periodic_ff;
      more_in          = more_ff;
      if (start) begin
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         best_found_in  = 1'b0;
         more_in        = 1'b0;
      end else if (chk_vld_ff) begin
         if (is_set) begin
            if (!match_found_ff && slot_valid && (rd_slot.id == next_id)) begin
               match_found_in = 1'b1;
               match_idx_in   = chk_idx_ff;
            end
            if (!free_found_ff && !slot_valid) begin
               free_found_in = 1'b1;
               free_idx_in   = chk_idx_ff;
            end
         end
         if (due) begin
            if (best_found_ff) begin
               more_in = 1'b1;
            end
            if (!best_found_ff || (rd_slot.id < best_id_ff)) begin
               best_found_in    = 1'b1;
               best_idx_in      = chk_idx_ff;
               best_id_in       = rd_slot.id;
               best_delay_in    = rd_slot.delay;
               best_periodic_in = rd_slot.periodic;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         chk_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         chk_vld_ff <= chk_vld_in;
      end
      iss_ff           <= iss_in;
      chk_idx_ff       <= chk_idx_in;
      match_found_ff   <= match_found_in;
      match_idx_ff     <= match_idx_in;
      free_found_ff    <= free_found_in;
      free_idx_ff      <= free_idx_in;
      best_found_ff    <= best_found_in;
      best_idx_ff      <= best_idx_in;
      best_id_ff       <= best_id_in;
      best_delay_ff    <= best_delay_in;
      best_periodic_ff <= best_periodic_in;
      more_ff          <= more_in;
   end

   assign rd_addr = iss_ff;
   assign chk_idx = chk_idx_ff;

   always_comb begin
      chk.vld     = chk_vld_ff;
      chk.done    = chk_vld_ff && (chk_idx_ff == LAST_IDX);
      chk.clr_hit = chk_vld_ff && (cmd == CMD_CLEAR) && slot_valid && (rd_slot.id == target);
      chk.due     = due;
   end

   always_comb begin
      res.match_found   = match_found_ff;
      res.free_found    = free_found_ff;
      res.best_found    = best_found_ff;
      res.best_periodic = best_periodic_ff;
      res.more          = more_ff;
   end

   assign match_idx  = match_idx_ff;
   assign free_idx   = free_idx_ff;
   assign best_idx   = best_idx_ff;
   assign best_id    = best_id_ff;
   assign best_delay = best_delay_ff;

endmodule

`default_nettype wire

/* sv/oneshot_periodic_timer_table_core.sv */
// channel | handshake            | payload
// --------+----------------------+-------------------------------------------------
// req     | req_valid/req_stall  | req_command, req_delay_ms, req_target_id, req_now_ms
// rsp     | rsp_valid/rsp_stall  | rsp_kind, rsp_timer_id, rsp_last
//
// Every item runs one scan of the slot memory, one slot a cycle; the next item
// is taken only when the block has returned to idle.
// A tick runs one scan per fired timer, up to 16.
// Synchronous reset empties the table and sets the id counter to one.
// A stalled rsp holds the block in its final step; a new item may be accepted
// while the last result still waits.
`default_nettype none

module oneshot_periodic_timer_table_core #(
   parameter int unsigned NUM_SLOTS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_command,
   input  wire logic [otmr_pkg::DELAY_W-1:0] req_delay_ms,
   input  wire logic [otmr_pkg::ID_W-1:0]   req_target_id,
   input  wire logic [otmr_pkg::TIME_W-1:0] req_now_ms,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [2:0]                  rsp_kind,
   output logic      [otmr_pkg::ID_W-1:0]   rsp_timer_id,
   output logic                             rsp_last
);

   import otmr_pkg::*;

   localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [FCNT_W-1:0] FIRE_LAST = FCNT_W'(MAX_FIRE - 1);

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [ID_W-1:0]    target_ff, target_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [ID_W-1:0]    next_id_ff, next_id_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [NUM_SLOTS-1:0] due_ff, due_in;
   logic               pass0_ff, pass0_in;
   logic [FCNT_W-1:0]  fire_cnt_ff, fire_cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]    rsp_timer_id_ff, rsp_timer_id_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               req_acc;
   logic               out_free;
   logic               scan_start;
   logic               emit;
   kind_type           emit_kind;
   logic [ID_W-1:0]    emit_id;
   logic               emit_last;
   logic               fire_last;
   logic               fire_more;

   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   slot_type           wr_slot;
   logic [$bits(slot_type)-1:0] rd_word;
   slot_type           rd_slot;
   logic [IW-1:0]      rd_addr;

   chk_type            chk;
   logic [IW-1:0]      chk_idx;
   scan_res_type       res;
   logic [IW-1:0]      match_idx;
   logic [IW-1:0]      free_idx;
   logic [IW-1:0]      best_idx;
   logic [ID_W-1:0]    best_id;
   logic [DELAY_W-1:0] best_delay;

   otmr_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (NUM_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_slot = slot_type'(rd_word);

   otmr_scan #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .cmd        (cmd_ff),
      .pass0      (pass0_ff),
      .next_id    (next_id_ff),
      .target     (target_ff),
      .now        (now_ff),
      .rd_slot    (rd_slot),
      .slot_valid (valid_ff[chk_idx]),
      .slot_due   (due_ff[chk_idx]),
      .rd_addr    (rd_addr),
      .chk        (chk),
      .chk_idx    (chk_idx),
      .res        (res),
      .match_idx  (match_idx),
      .free_idx   (free_idx),
      .best_idx   (best_idx),
      .best_id    (best_id),
      .best_delay (best_delay)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire_last = !res.more || (fire_cnt_ff == FIRE_LAST);
   assign fire_more = (cmd_ff == CMD_TICK) && res.best_found && !fire_last;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (chk.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = fire_more ? ST_SCAN : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      scan_start  = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = best_idx;
      wr_slot     = '{id: best_id, delay: best_delay, periodic: res.best_periodic,
                      deadline: sat_add(now_ff, best_delay)};
      emit        = 1'b0;
      emit_kind   = KIND_NONE;
      emit_id     = '0;
      emit_last   = 1'b1;
      cmd_in      = cmd_ff;
      delay_in    = delay_ff;
      target_in   = target_ff;
      now_in      = now_ff;
      next_id_in  = next_id_ff;
      valid_in    = valid_ff;
      due_in      = due_ff;
      pass0_in    = pass0_ff;
      fire_cnt_in = fire_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cmd_in      = cmd_type'(req_command);
               delay_in    = req_delay_ms;
               target_in   = req_target_id;
               now_in      = req_now_ms;
               scan_start  = 1'b1;
               pass0_in    = 1'b1;
               fire_cnt_in = '0;
            end
         end
         ST_SCAN: begin
            if (chk.clr_hit) valid_in[chk_idx] = 1'b0;
            if (pass0_ff && chk.vld && (cmd_ff == CMD_TICK)) due_in[chk_idx] = chk.due;
         end
         ST_DONE: begin
            if (out_free) begin
               emit = 1'b1;
               unique case (cmd_ff)
                  CMD_TIMEOUT, CMD_INTERVAL: begin
                     if (res.match_found || res.free_found) begin
                        wr_en   = 1'b1;
                        wr_addr = res.match_found ? match_idx : free_idx;
                        wr_slot = '{id: next_id_ff, delay: delay_ff,
                                    periodic: (cmd_ff == CMD_INTERVAL),
                                    deadline: sat_add(now_ff, delay_ff)};
                        valid_in[wr_addr] = 1'b1;
                        emit_kind  = KIND_ASSIGNED;
                        emit_id    = next_id_ff;
                        next_id_in = (next_id_ff == ID_LAST) ? ID_FIRST : next_id_ff + 1'b1;
                     end else begin
                        emit_kind = KIND_FULL;
                     end
                  end
                  CMD_CLEAR: begin
                     emit_kind = KIND_CLEARED;
                     emit_id   = target_ff;
                  end
                  CMD_TICK: begin
                     if (res.best_found) begin
                        emit_kind        = KIND_FIRED;
                        emit_id          = best_id;
                        emit_last        = fire_last;
                        due_in[best_idx] = 1'b0;
                        if (res.best_periodic) begin
                           wr_en = 1'b1;
                        end else begin
                           valid_in[best_idx] = 1'b0;
                        end
                        if (!fire_last) begin
                           scan_start  = 1'b1;
                           pass0_in    = 1'b0;
                           fire_cnt_in = fire_cnt_ff + 1'b1;
                        end
                     end else begin
                        emit_kind = KIND_NONE;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in    = emit || (rsp_valid_ff && rsp_stall);
   assign rsp_kind_in     = emit ? emit_kind : rsp_kind_ff;
   assign rsp_timer_id_in = emit ? emit_id : rsp_timer_id_ff;
   assign rsp_last_in     = emit ? emit_last : rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_id_ff   <= ID_FIRST;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_id_ff   <= next_id_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff          <= cmd_in;
      delay_ff        <= delay_in;
      target_ff       <= target_in;
      now_ff          <= now_in;
      due_ff          <= due_in;
      pass0_ff        <= pass0_in;
      fire_cnt_ff     <= fire_cnt_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_timer_id_ff <= rsp_timer_id_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_timer_id = rsp_timer_id_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

/* sv/otmr_chk.sv */
`default_nettype none
`include "assert_macros.svh"

module otmr_chk (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_stall,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [2:0]                  rsp_kind,
   input wire logic [otmr_pkg::ID_W-1:0]   rsp_timer_id,
   input wire logic                        rsp_last
);

   import otmr_pkg::*;

   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_timer_id) && $stable(rsp_last), "stalled rsp item changed")

   `ASSERT_RST(a_single_last, clock, reset, rsp_valid && (rsp_kind == KIND_ASSIGNED || rsp_kind == KIND_CLEARED || rsp_kind == KIND_FULL || rsp_kind == KIND_NONE) |-> rsp_last, "single result item without last")

   `ASSERT_RST(a_zero_id, clock, reset, rsp_valid && (rsp_kind == KIND_FULL || rsp_kind == KIND_NONE) |-> rsp_timer_id == '0, "full or none item with nonzero id")

   `ASSERT_RST(a_id_nonzero, clock, reset, rsp_valid && rsp_kind == KIND_ASSIGNED |-> rsp_timer_id != '0, "assigned id zero")

   `ASSERT_CLK(a_reset_idle, clock, $past(reset) |-> !rsp_valid && !req_stall, "not idle after reset")

endmodule

bind oneshot_periodic_timer_table_core otmr_chk u_otmr_chk (.*);

`default_nettype wire
